>>> rtl/hsfc_pkg.sv
// Package: opcodes and constants for the half/single float converter.
`default_nettype none
package hsfc_pkg;
	typedef enum logic {
		OP_H2S = 1'b0,
		OP_S2H = 1'b1
	} op_t;

	localparam logic [31:0] QNAN_SINGLE = 32'h7FC0_0000;
	localparam logic [31:0] INF_SINGLE  = 32'h7F80_0000;
	localparam logic [14:0] INF_HALF    = 15'h7C00;
	localparam logic [14:0] NAN_HALF    = 15'h7C01;

	typedef struct packed {
		op_t         op;
		logic        sign;
		logic [7:0]  exp;
		logic [22:0] frac;
	} s1_t;
endpackage
`default_nettype wire

>>> rtl/half_single_float_converter_top.sv
// Top level: three-stage pipelined half/single float converter.
// One item is taken every cycle (busy is always low); each result appears
// on result_bits with done high after it has passed the three pipeline
// registers: field unpack, then leading-one search / shift amount, then
// pack. The receiver cannot stall.
`default_nettype none
module half_single_float_converter_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         opcode,
	input  wire  [31:0] operand_bits,
	output logic        done,
	output logic [31:0] result_bits
);
	import hsfc_pkg::*;

	s1_t         s1;
	logic        v_s1;
	logic        v_s2, sign_s2;
	op_t         op_s2;
	logic [2:0]  cls_s2;
	logic [7:0]  exp_s2;
	logic [22:0] frac_s2;
	logic [4:0]  sh_s2;
	logic        done_s3;
	logic [31:0] res_s3;

	localparam logic [2:0] C_ZERO = 3'd0, C_NORM = 3'd1, C_SUB = 3'd2,
		C_INF = 3'd3, C_NAN = 3'd4;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		s1.op <= op_t'(opcode);
		if (opcode == OP_H2S) begin
			s1.sign <= operand_bits[15];
			s1.exp  <= {3'b000, operand_bits[14:10]};
			s1.frac <= {operand_bits[9:0], 13'd0};
		end else begin
			s1.sign <= operand_bits[31];
			s1.exp  <= operand_bits[30:23];
			s1.frac <= operand_bits[22:0];
		end
	end

	logic [2:0] cls_d;
	logic [4:0] sh_d;
	always_comb begin
		cls_d = C_NORM;
		sh_d  = 5'd0;
		if (s1.op == OP_H2S) begin
			if (s1.exp[4:0] == 5'd0) begin
				cls_d = (s1.frac[22:13] == 10'd0) ? C_ZERO : C_SUB;
				for (int i = 0; i < 10; i++)
					if (s1.frac[13 + i]) sh_d = 5'(9 - i);
			end else if (s1.exp[4:0] == 5'd31) begin
				cls_d = (s1.frac[22:13] != 10'd0) ? C_NAN : C_INF;
			end
		end else begin
			if (s1.exp == 8'hFF) cls_d = (s1.frac != 23'd0) ? C_NAN : C_INF;
			else if (s1.exp > 8'd142) cls_d = C_INF;
			else if (s1.exp < 8'd102) cls_d = C_ZERO;
			else if (s1.exp <= 8'd112) begin
				cls_d = C_SUB;
				sh_d  = 5'(8'd113 - s1.exp);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		op_s2 <= s1.op; sign_s2 <= s1.sign; exp_s2 <= s1.exp;
		frac_s2 <= s1.frac; cls_s2 <= cls_d; sh_s2 <= sh_d;
	end

	logic [31:0] r_d;
	logic [22:0] hsub;
	logic [23:0] ssub;
	always_comb begin
		hsub = frac_s2 << (sh_s2 + 5'd1);
		ssub = {1'b1, frac_s2} >> sh_s2;
		r_d  = 32'd0;
		if (op_s2 == OP_H2S) begin
			case (cls_s2)
				C_ZERO:  r_d = {sign_s2, 31'd0};
				C_SUB:   r_d = {sign_s2, 8'(8'd112 - {3'd0, sh_s2}), hsub};
				C_INF:   r_d = {sign_s2, 31'd0} | INF_SINGLE;
				C_NAN:   r_d = QNAN_SINGLE;
				default: r_d = {sign_s2, 8'(exp_s2 + 8'd112), frac_s2};
			endcase
		end else begin
			case (cls_s2)
				C_ZERO:  r_d = {16'd0, sign_s2, 15'd0};
				C_SUB:   r_d = {16'd0, sign_s2, 5'd0, ssub[22:13]};
				C_INF:   r_d = {16'd0, sign_s2, INF_HALF};
				C_NAN:   r_d = {16'd0, sign_s2, NAN_HALF};
				default: r_d = {16'd0, sign_s2, 5'(exp_s2 - 8'd112), frac_s2[22:13]};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s3 <= 1'b0;
		else done_s3 <= v_s2;
	end
	always_ff @(posedge clk) res_s3 <= r_d;

	assign done = done_s3;
	assign result_bits = res_s3;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done) else $error("lost transfer");
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##3 !done) else $error("invented transfer");
	a_half_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && op_s2 == OP_S2H) |=> result_bits[31:16] == 16'd0)
		else $error("half result upper bits set");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the half/single float converter: directed and random conversions checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
	import hsfc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        opcode;
	logic [31:0] operand_bits;
	logic        done;
	logic [31:0] result_bits;

	logic [31:0] expected_results[$];
	int          error_count;
	int          cycle_count;
	bit          no_idle;

	half_single_float_converter_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.operand_bits(operand_bits),
		.done(done),
		.result_bits(result_bits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [31:0] sgn;
		logic [4:0]  ex;
		logic [9:0]  fr;
		int          p;
		sgn = {h[15], 31'b0};
		ex = h[14:10];
		fr = h[9:0];
		if (ex == 5'd0) begin
			if (fr == 10'd0) return sgn;
			p = 9;
			while (fr[p] == 1'b0) p--;
			return sgn | (32'(p + 103) << 23) | ((32'(fr) << (23 - p)) & 32'h007F_FFFF);
		end
		if (ex == 5'd31) begin
			if (fr != 10'd0) return QNAN_SINGLE;
			return sgn | INF_SINGLE;
		end
		return sgn | (32'(ex + 112) << 23) | (32'(fr) << 13);
	endfunction

	function automatic logic [31:0] narrow_single(input logic [31:0] f);
		logic [15:0] sgn;
		int          ex;
		logic [31:0] fr;
		sgn = {f[31], 15'b0};
		ex = int'(f[30:23]) - 112;
		fr = {9'b0, f[22:0]};
		if (ex <= 0) begin
			if (ex < -10) return {16'b0, sgn};
			fr = (fr | 32'h0080_0000) >> (1 - ex);
			return {16'b0, sgn | fr[28:13]};
		end
		if (ex == 255 - 112) return {16'b0, sgn | {1'b0, (fr != 0) ? NAN_HALF : INF_HALF}};
		if (ex > 30) return {16'b0, sgn | {1'b0, INF_HALF}};
		return {16'b0, sgn | 16'(ex << 10) | fr[28:13]};
	endfunction

	task automatic send_conversion(input op_t op, input logic [31:0] value);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		operand_bits <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(op == OP_H2S ? widen_half(value[15:0]) : narrow_single(value));
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result_bits: unexpected result %h", result_bits);
				error_count++;
			end else begin
				if (result_bits !== expected_results[0]) begin
					$error("result_bits: expected %h actual %h", expected_results[0], result_bits);
					error_count++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_half_to_single_directed();
		logic [15:0] cases[] = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0200, 16'h0400,
			16'h3C00, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'hFE00, 16'h7FFF};
		foreach (cases[i]) send_conversion(OP_H2S, {16'hA5A5, cases[i]});
		send_conversion(OP_H2S, 32'hFFFF_3C00);
	endtask

	task automatic test_single_to_half_directed();
		logic [31:0] cases[] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3300_0000,
			32'h3380_0000, 32'hB37F_FFFF, 32'h387F_FFFF, 32'h3880_0000, 32'h3F80_1FFF,
			32'h477F_E000, 32'hC780_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
			32'h7F80_0001, 32'hFFFF_FFFF};
		foreach (cases[i]) send_conversion(OP_S2H, cases[i]);
	endtask

	task automatic test_random_conversions(input int count);
		logic [31:0] value;
		op_t         op;
		for (int i = 0; i < count; i++) begin
			value = $urandom;
			op = op_t'($urandom_range(0, 1));
			if (op == OP_S2H && $urandom_range(0, 1)) value[30:23] = 8'($urandom_range(100, 145));
			if ($urandom_range(0, 15) == 0) value[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			if (i >= count - 200) no_idle = 1'b1;
			send_conversion(op, value);
		end
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		start = 1'b0;
		opcode = 1'b0;
		operand_bits = 32'b0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_half_to_single_directed();
		test_single_to_half_directed();
		test_random_conversions(1800);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
